FILE: sv/trf_pkg.sv
//------------------------------------------------------------------------------
// trf_pkg
// Shared types, constants and tables for the tilt rotation filter.
//------------------------------------------------------------------------------
package trf_pkg;

    localparam int WINDOW_DEF       = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int GYRO_DIV         = 1025;

    localparam logic [CFG_IDX_W-1:0] REG_ABOUT_AXIS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS1_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS2_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS1_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS2_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_THRESH = 3'd6;

    localparam logic [1:0] SRC_ACCEL = 2'd0;
    localparam logic [1:0] SRC_GYRO  = 2'd1;
    localparam logic [1:0] SRC_HOLD  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture sample, read window slot
        logic fill;      // first sample: load sums and start fill sweep
        logic update;    // update sums with read-back slot
        logic decide;    // evaluate range tests, set up cordic
        logic iter;      // one cordic micro-rotation
        logic gyro_mul;  // register gyro product
        logic gyro_div;  // one reduction pass of gyro divide
        logic finish;    // write angle and result
    } t_cmd;

    typedef struct packed {
        logic        in1;      // axis1 within limits
        logic        in2;      // axis2 within limits
        logic        fill_done;
        logic        iter_done;
        logic        div_done;
    } t_sts;

    // atan(2^-i) in 1/4096 degree, rounded to nearest
    function automatic logic [17:0] atan_lut(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:  v = 18'd184320;
            5'd1:  v = 18'd108810;
            5'd2:  v = 18'd57492;
            5'd3:  v = 18'd29184;
            5'd4:  v = 18'd14649;
            5'd5:  v = 18'd7331;
            5'd6:  v = 18'd3667;
            5'd7:  v = 18'd1833;
            5'd8:  v = 18'd917;
            5'd9:  v = 18'd458;
            5'd10: v = 18'd229;
            5'd11: v = 18'd115;
            5'd12: v = 18'd57;
            5'd13: v = 18'd29;
            5'd14: v = 18'd14;
            5'd15: v = 18'd7;
            5'd16: v = 18'd4;
            5'd17: v = 18'd2;
            5'd18: v = 18'd1;
            default: v = 18'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/trf_ram.sv
//------------------------------------------------------------------------------
// trf_ram
// Generic single-port-write, single-port-read RAM with registered read.
//------------------------------------------------------------------------------
module trf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/trf_ctrl.sv
//------------------------------------------------------------------------------
// trf_ctrl
// Sequencer: issues load, window fill or update, decision, cordic, gyro and finish steps.
//------------------------------------------------------------------------------
module trf_ctrl
    import trf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_acc,
    input  logic i_out_free,
    input  t_sts i_sts,
    output logic o_busy,
    output t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_UPD, S_FILL, S_DEC, S_CORD, S_GMUL, S_GDIV
    } t_state;

    t_state r_state, n_state;
    logic   r_first, n_first;
    logic   r_fin_pending, n_fin_pending;

    always_comb begin
        n_state       = r_state;
        n_first       = r_first;
        n_fin_pending = 1'b0;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                if (r_first) begin
                    o_cmd.fill = 1'b1;
                    n_first    = 1'b0;
                    n_state    = S_FILL;
                end else begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_DEC;
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                if (!i_sts.in1) begin
                    n_state = S_GMUL;
                end else if (i_sts.in2) begin
                    n_state = S_CORD;
                end else begin
                    n_fin_pending = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_CORD: begin
                o_cmd.iter = 1'b1;
                if (i_sts.iter_done) begin
                    n_fin_pending = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_GMUL: begin
                o_cmd.gyro_mul = 1'b1;
                n_state        = S_GDIV;
            end
            S_GDIV: begin
                o_cmd.gyro_div = 1'b1;
                if (i_sts.div_done) begin
                    n_fin_pending = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.finish = r_fin_pending;
    end

    // Idle only accepts when output register is free and no finish pending
    assign o_busy = (r_state != S_IDLE) || r_fin_pending || !i_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_first       <= 1'b1;
            r_fin_pending <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_first       <= n_first;
            r_fin_pending <= n_fin_pending;
        end
    end
endmodule

FILE: sv/trf_dp.sv
//------------------------------------------------------------------------------
// trf_dp
// Datapath: window RAMs with running sums, range test, iterative cordic
// atan2 and shift-and-subtract gyro integration divide.
//------------------------------------------------------------------------------
module trf_dp
    import trf_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [1:0]           i_about_axis,
    input  logic signed [15:0]   i_axis1_offset,
    input  logic signed [15:0]   i_axis2_offset,
    input  logic [14:0]          i_axis1_limit,
    input  logic [14:0]          i_axis2_limit,
    input  logic signed [15:0]   i_gyro_offset,
    input  logic signed [12:0]   i_angle_threshold,
    input  logic signed [15:0]   i_accel_x,
    input  logic signed [15:0]   i_accel_y,
    input  logic signed [15:0]   i_accel_z,
    input  logic signed [15:0]   i_gyro_rate,
    input  logic [15:0]          i_elapsed_ms,
    output logic signed [15:0]   o_angle,
    output logic                 o_below_thresh,
    output logic [1:0]           o_source
);
    localparam int AW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW   = 16 + $clog2(WINDOW) + 1;   // sum width
    localparam int AV   = SW + 2;                    // corrected sum width
    localparam int CW   = AV + 3;                    // cordic x/y width
    localparam int ZW   = 22;                        // angle accumulator
    localparam int SC_W = $clog2(CORDIC_STEPS + 1);
    localparam int PW   = 34;                        // gyro product width
    localparam int RW   = PW + 1;                    // signed remainder width
    localparam int QW   = 25;                        // signed quotient width
    localparam int DIV_PASSES = 4;

    // Sample capture
    logic signed [15:0] r_v1, r_v2, r_gyro;
    logic [15:0]        r_ms;
    logic signed [15:0] n_v1, n_v2;

    always_comb begin
        case (i_about_axis)
            AXIS_Y: begin n_v1 = i_accel_x; n_v2 = i_accel_z; end
            AXIS_Z: begin n_v1 = i_accel_x; n_v2 = i_accel_y; end
            default: begin n_v1 = i_accel_y; n_v2 = i_accel_z; end
        endcase
    end

    // Window storage
    logic [AW-1:0]      r_slot, r_fill_addr;
    logic               r_filling;
    logic [15:0]        w_old1, w_old2;
    logic               w_we;
    logic [AW-1:0]      w_waddr;

    assign w_we    = r_filling || i_cmd.update;
    assign w_waddr = r_filling ? r_fill_addr : r_slot;

    trf_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ram1 (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_v1),
        .i_raddr(r_slot), .o_rdata(w_old1));
    trf_ram #(.WIDTH(16), .DEPTH(WINDOW)) u_ram2 (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_v2),
        .i_raddr(r_slot), .o_rdata(w_old2));

    logic signed [SW-1:0] r_sum1, r_sum2;

    assign o_sts.fill_done = r_filling && (r_fill_addr == AW'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_fill_addr <= '0;
            r_filling   <= 1'b0;
            r_sum1      <= '0;
            r_sum2      <= '0;
        end else begin
            if (i_cmd.fill) begin
                r_filling   <= 1'b1;
                r_fill_addr <= '0;
                r_sum1      <= SW'(r_v1) * SW'(WINDOW);
                r_sum2      <= SW'(r_v2) * SW'(WINDOW);
            end else if (r_filling) begin
                r_fill_addr <= r_fill_addr + 1'b1;
                if (o_sts.fill_done) begin
                    r_filling <= 1'b0;
                end
            end
            if (i_cmd.update) begin
                r_sum1 <= r_sum1 + SW'(r_v1) - SW'($signed(w_old1));
                r_sum2 <= r_sum2 + SW'(r_v2) - SW'($signed(w_old2));
                r_slot <= (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_v1   <= n_v1;
            r_v2   <= n_v2;
            r_gyro <= i_gyro_rate;
            r_ms   <= i_elapsed_ms;
        end
    end

    // Range tests (offset*W, limit*W are constant multiplies)
    logic signed [AV-1:0] w_a1, w_a2, w_l1, w_l2;
    assign w_a1 = AV'(r_sum1) - (AV'(i_axis1_offset) * AV'(WINDOW));
    assign w_a2 = AV'(r_sum2) - (AV'(i_axis2_offset) * AV'(WINDOW));
    assign w_l1 = AV'({1'b0, i_axis1_limit}) * AV'(WINDOW);
    assign w_l2 = AV'({1'b0, i_axis2_limit}) * AV'(WINDOW);
    assign o_sts.in1 = (w_a1 >= -w_l1) && (w_a1 <= w_l1);
    assign o_sts.in2 = (w_a2 >= -w_l2) && (w_a2 <= w_l2);

    // CORDIC vectoring
    logic signed [CW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic [SC_W-1:0]      r_step;
    logic                 r_zero;
    logic signed [CW-1:0] w_xs, w_ys;
    logic signed [ZW-1:0] w_at;

    assign w_xs = r_x >>> r_step;
    assign w_ys = r_y >>> r_step;
    assign w_at = ZW'($signed({1'b0, atan_lut(5'(r_step))}));
    assign o_sts.iter_done = r_zero || (r_step == SC_W'(CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_step <= '0;
            r_zero <= (w_a1 == '0) && (w_a2 == '0);
            if (w_a2 < 0) begin
                r_x <= -CW'(w_a2);
                r_y <= -CW'(w_a1);
                r_z <= (w_a1 >= 0) ? ZW'(180 * 4096) : -ZW'(180 * 4096);
            end else begin
                r_x <= CW'(w_a2);
                r_y <= CW'(w_a1);
                r_z <= '0;
            end
        end else if (i_cmd.iter && !r_zero) begin
            r_step <= r_step + 1'b1;
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_at;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_at;
            end
        end
    end

    // z/256 rounded half away from zero; fits 16 bits already
    logic [ZW-1:0]        w_zmag;
    logic [ZW-1:0]        w_zq;
    logic signed [15:0]   w_cord_angle;
    assign w_zmag = r_z[ZW-1] ? ZW'(-r_z) : ZW'(r_z);
    assign w_zq   = (w_zmag + ZW'(128)) >> 8;
    assign w_cord_angle = r_zero ? 16'sd0
                        : (r_z[ZW-1] ? -$signed(w_zq[15:0]) : $signed(w_zq[15:0]));

    // Gyro: |d| rounded over 1025 = 2^10 + 1. Each pass takes t = rem/1024
    // (floor), adds t to the quotient and removes 1025*t from the remainder;
    // four passes leave the remainder in [0, 1024], so the quotient is exact.
    logic                 r_neg;
    logic signed [RW-1:0] r_rem;
    logic signed [QW-1:0] r_quo;
    logic [1:0]           r_qcnt;
    logic signed [16:0]   w_g;
    logic signed [PW-1:0] w_prod;
    logic signed [RW-1:0] w_t;

    assign w_g    = 17'(r_gyro) - 17'(i_gyro_offset);
    assign w_prod = PW'(w_g) * PW'($signed({1'b0, r_ms}));
    assign w_t    = r_rem >>> 10;
    assign o_sts.div_done = (r_qcnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.gyro_mul) begin
            r_neg  <= w_prod[PW-1];
            r_rem  <= RW'(w_prod[PW-1] ? -w_prod : w_prod) + RW'(GYRO_DIV / 2);
            r_quo  <= '0;
            r_qcnt <= 2'(DIV_PASSES - 1);
        end else if (i_cmd.gyro_div) begin
            r_qcnt <= r_qcnt - 1'b1;
            r_rem  <= r_rem - (w_t <<< 10) - w_t;
            r_quo  <= r_quo + QW'(w_t);
        end
    end

    // Angle state and result registers
    logic signed [QW-1:0] w_gsum;
    logic signed [15:0]   w_gyro_angle;
    logic [1:0]           r_src_sel;
    assign w_gsum = QW'(o_angle) + (r_neg ? -r_quo : r_quo);
    assign w_gyro_angle = (w_gsum > QW'(32767)) ? 16'sh7FFF
                        : (w_gsum < -QW'(32768)) ? -16'sh8000 : w_gsum[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_angle   <= '0;
            r_src_sel <= SRC_HOLD;
        end else begin
            if (i_cmd.decide) begin
                r_src_sel <= !o_sts.in1 ? SRC_GYRO : (o_sts.in2 ? SRC_ACCEL : SRC_HOLD);
            end
            if (i_cmd.finish) begin
                if (r_src_sel == SRC_ACCEL) begin
                    o_angle <= w_cord_angle;
                end else if (r_src_sel == SRC_GYRO) begin
                    o_angle <= w_gyro_angle;
                end
            end
        end
    end

    assign o_source       = r_src_sel;
    assign o_below_thresh = (17'(o_angle) < 17'(i_angle_threshold));
endmodule

FILE: sv/tilt_rotation_filter_core.sv
//------------------------------------------------------------------------------
// tilt_rotation_filter_core
// Tilt angle from a sliding accelerometer average with gyro fallback.
//------------------------------------------------------------------------------
// Usage:
//   Slave stream (s_axis_*) takes one IMU sample per beat. Master stream
//   (m_axis_*) returns one result beat per sample: the angle in 1/16 degree,
//   the threshold class and the source of the angle (accel, gyro or held).
//   Configuration writes go over the cfg channel (index + data); always ready.
// Sequence from accept to result valid: load, window read and update,
//   decision, then the path step; finish writes the angle and the result
//   register captures it. Accel path: iterative CORDIC, one micro-rotation
//   per cycle; it stops without rotating when both averages are zero.
//   Gyro path: product, then four shift-and-subtract passes of the divide.
//   Held path: no path step. The first sample after reset does a window
//   fill, one RAM entry per cycle, in place of the window update.
// Throughput: one sample in flight at a time; the next is taken the cycle
//   after the result beat leaves.
// Reset: synchronous, active low; clears sums, angle and registers to their
//   defaults; the window RAM content is undefined until the first sample.
// Stall: a result waits in the output register while m_axis_tready is low;
//   the input is held off until that beat leaves.
//------------------------------------------------------------------------------
module tilt_rotation_filter_core
    import trf_pkg::*;
#(
    parameter int WINDOW       = WINDOW_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_rate[63:48],
    // elapsed_ms[79:64]
    input  logic [79:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // angle_sixteenths[15:0], below_thresh[16], angle_source[18:17], zero pad
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    // Config registers
    logic [1:0]         r_about_axis;
    logic signed [15:0] r_axis1_offset, r_axis2_offset, r_gyro_offset;
    logic [14:0]        r_axis1_limit, r_axis2_limit;
    logic signed [12:0] r_angle_threshold;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_about_axis      <= '0;
            r_axis1_offset    <= '0;
            r_axis2_offset    <= '0;
            r_axis1_limit     <= 15'd16384;
            r_axis2_limit     <= 15'd16384;
            r_gyro_offset     <= '0;
            r_angle_threshold <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ABOUT_AXIS:   r_about_axis      <= i_cfg_data[1:0];
                REG_AXIS1_OFFSET: r_axis1_offset    <= i_cfg_data;
                REG_AXIS2_OFFSET: r_axis2_offset    <= i_cfg_data;
                REG_AXIS1_LIMIT:  r_axis1_limit     <= i_cfg_data[14:0];
                REG_AXIS2_LIMIT:  r_axis2_limit     <= i_cfg_data[14:0];
                REG_GYRO_OFFSET:  r_gyro_offset     <= i_cfg_data;
                REG_ANGLE_THRESH: r_angle_threshold <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Handshake
    logic  w_busy, w_in_acc;
    t_cmd  w_cmd;
    t_sts  w_sts;
    logic signed [15:0] w_angle;
    logic  w_below;
    logic [1:0] w_src;
    logic  r_cap;

    assign s_axis_tready = !w_busy;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // Hold off input while a result is being captured or still waits
    trf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_acc(w_in_acc),
        .i_out_free(!m_axis_tvalid && !r_cap), .i_sts(w_sts), .o_busy(w_busy),
        .o_cmd(w_cmd));

    trf_dp #(.WINDOW(WINDOW), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_about_axis(r_about_axis),
        .i_axis1_offset(r_axis1_offset), .i_axis2_offset(r_axis2_offset),
        .i_axis1_limit(r_axis1_limit), .i_axis2_limit(r_axis2_limit),
        .i_gyro_offset(r_gyro_offset), .i_angle_threshold(r_angle_threshold),
        .i_accel_x(s_axis_tdata[15:0]), .i_accel_y(s_axis_tdata[31:16]),
        .i_accel_z(s_axis_tdata[47:32]), .i_gyro_rate(s_axis_tdata[63:48]),
        .i_elapsed_ms(s_axis_tdata[79:64]),
        .o_angle(w_angle), .o_below_thresh(w_below), .o_source(w_src));

    // Result register: capture on r_cap, a registered copy of finish, so angle is settled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap         <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_cap <= w_cmd.finish;
            if (r_cap) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cap) begin
            m_axis_tdata <= {5'd0, w_src, w_below, w_angle};
        end
    end
endmodule

FILE: sv/trf_checker.sv
//------------------------------------------------------------------------------
// trf_checker
// Port-level checks of the tilt rotation filter core.
//------------------------------------------------------------------------------
module trf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No new sample while a result waits
    a_nooverlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    // Source code is never the unused value
    a_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[18:17] != 2'd3)
        else $error("bad angle source");

    // After a sample is taken, the block is busy next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");
endmodule

bind tilt_rotation_filter_core trf_checker u_trf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata));

FILE: tb/tb_tilt_rotation_filter_core.sv
//------------------------------------------------------------------------------
// tb_tilt_rotation_filter_core
// Self-checking bench: IMU sample beats in, predicted tilt angle, threshold
// class and angle source compared beat by beat, over several register sets.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tilt_rotation_filter_core
    import trf_pkg::*;
;

    localparam int WIN   = 16;
    localparam int STEPS = 16;

    typedef struct packed {
        logic signed [15:0] angle;
        logic               below;
        logic [1:0]         source;
    } t_tilt;

    // Mismatch counter and report task
    int errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Scoreboard: tilt predictor with its own register and window copy
    class tilt_scoreboard;
        logic [1:0]         about;
        logic signed [15:0] off1, off2, gyro_off;
        logic [14:0]        lim1, lim2;
        logic signed [12:0] thresh;
        logic signed [15:0] win1 [WIN];
        logic signed [15:0] win2 [WIN];
        longint             sum1, sum2;
        int                 slot;
        bit                 filling;
        int                 angle;
        t_tilt              pending[$];

        function new();
            about = AXIS_X; off1 = 0; off2 = 0; gyro_off = 0;
            lim1 = 15'd16384; lim2 = 15'd16384; thresh = 0;
            sum1 = 0; sum2 = 0; slot = 0; filling = 1; angle = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            case (idx)
                REG_ABOUT_AXIS:   about    = val[1:0];
                REG_AXIS1_OFFSET: off1     = val;
                REG_AXIS2_OFFSET: off2     = val;
                REG_AXIS1_LIMIT:  lim1     = val[14:0];
                REG_AXIS2_LIMIT:  lim2     = val[14:0];
                REG_GYRO_OFFSET:  gyro_off = val;
                REG_ANGLE_THRESH: thresh   = val[12:0];
                default: ;
            endcase
        endfunction

        static function longint fshr(longint v, int s);
            return v >>> s;
        endfunction

        static function longint rdiv(longint n, longint d);
            if (n >= 0) return (n + d / 2) / d;
            return -((-n + d / 2) / d);
        endfunction

        static function int clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return int'(v);
        endfunction

        static function int vector_angle(longint y, longint x);
            longint z, xs, ys;
            z = 0;
            if (x == 0 && y == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? 180 * 4096 : -180 * 4096;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < STEPS; i++) begin
                xs = fshr(x, i);
                ys = fshr(y, i);
                if (y > 0) begin
                    x = x + ys; y = y - xs; z += longint'(atan_lut(i[4:0]));
                end else begin
                    x = x - ys; y = y + xs; z -= longint'(atan_lut(i[4:0]));
                end
            end
            return clamp16(rdiv(z, 256));
        endfunction

        // Note an accepted sample beat and queue its predicted result
        function void note_sample(logic [79:0] d);
            logic signed [15:0] ax, ay, az, gr, v1, v2;
            longint a1, a2, l1, l2;
            t_tilt r;
            ax = d[15:0]; ay = d[31:16]; az = d[47:32]; gr = d[63:48];
            if (about == AXIS_Y) begin
                v1 = ax; v2 = az;
            end else if (about == AXIS_Z) begin
                v1 = ax; v2 = ay;
            end else begin
                v1 = ay; v2 = az;
            end
            if (filling) begin
                for (int k = 0; k < WIN; k++) begin
                    win1[k] = v1; win2[k] = v2;
                end
                sum1 = longint'(v1) * WIN;
                sum2 = longint'(v2) * WIN;
                slot = 0;
                filling = 0;
            end else begin
                sum1 += longint'(v1) - longint'(win1[slot]);
                sum2 += longint'(v2) - longint'(win2[slot]);
                win1[slot] = v1; win2[slot] = v2;
                slot = (slot + 1) % WIN;
            end
            a1 = sum1 - longint'(off1) * WIN;
            a2 = sum2 - longint'(off2) * WIN;
            l1 = longint'(lim1) * WIN;
            l2 = longint'(lim2) * WIN;
            if (a1 >= -l1 && a1 <= l1) begin
                if (a2 >= -l2 && a2 <= l2) begin
                    angle = vector_angle(a1, a2);
                    r.source = SRC_ACCEL;
                end else begin
                    r.source = SRC_HOLD;
                end
            end else begin
                angle = clamp16(longint'(angle) + rdiv((longint'(gr) - longint'(gyro_off))
                                * longint'(d[79:64]), GYRO_DIV));
                r.source = SRC_GYRO;
            end
            r.angle = angle[15:0];
            r.below = (angle >= int'(thresh)) ? 1'b0 : 1'b1;
            pending.push_back(r);
        endfunction

        // Check one result beat against the oldest prediction
        task check_result(logic [23:0] d);
            t_tilt w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result beat", int'(d), 0);
                return;
            end
            w = pending.pop_front();
            if (d[15:0] !== w.angle)
                report_mismatch("angle", int'($signed(d[15:0])), int'(w.angle));
            if (d[16] !== w.below)
                report_mismatch("below_thresh", int'(d[16]), int'(w.below));
            if (d[18:17] !== w.source)
                report_mismatch("angle_source", int'(d[18:17]), int'(w.source));
            if (d[23:19] !== 5'd0)
                report_mismatch("pad bits", int'(d[23:19]), 0);
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [79:0]          s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [15:0]          i_cfg_data;

    tilt_rotation_filter_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    tilt_scoreboard sb = new();
    bit idle_on = 1;     // random gaps and stalls enabled

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Result side: sample at the rising edge, randomize stalls at the falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial begin
        int stall;
        m_axis_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall = $urandom_range(1, 8) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Write one register; hold until the channel takes the beat, then drop valid and idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Send one sample beat, with an optional random gap first. Valid stays
    // high on return; the next call or drain() drives it.
    task automatic send_sample(input logic [79:0] d);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(d);
        @(negedge i_clk);
    endtask

    function automatic logic [79:0] pack_sample(int ax, int ay, int az, int gr, int ms);
        return {ms[15:0], gr[15:0], az[15:0], ay[15:0], ax[15:0]};
    endfunction

    // Accel value near a level, so the window average crosses the limits often
    function automatic logic [15:0] near(int level);
        int v;
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        v = level + $signed($urandom_range(0, 4000)) - 2000;
        return 16'(v);
    endfunction

    // Drain: drop valid, wait until every predicted beat has arrived, then pause
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic random_regs(input bit extremes);
        write_reg(REG_ABOUT_AXIS, 16'($urandom_range(0, 3)));
        write_reg(REG_AXIS1_OFFSET, extremes ? 16'h8000 : 16'($urandom_range(0, 4000) - 2000));
        write_reg(REG_AXIS2_OFFSET, extremes ? 16'h7FFF : 16'($urandom_range(0, 4000) - 2000));
        write_reg(REG_AXIS1_LIMIT, extremes ? 16'h7FFF : 16'($urandom_range(0, 20000)));
        write_reg(REG_AXIS2_LIMIT, extremes ? 16'h0000 : 16'($urandom_range(0, 20000)));
        write_reg(REG_GYRO_OFFSET, extremes ? 16'h8000 : 16'($urandom()));
        write_reg(REG_ANGLE_THRESH, 16'($urandom_range(0, 5760) - 2880));
    endtask

    initial begin
        int lvl1, lvl2;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ABOUT_AXIS;
        i_cfg_data    = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: reset registers, first-sample fill, zero vector, axis2 negative
        send_sample(pack_sample(0, 0, 0, 0, 0));
        send_sample(pack_sample(0, 0, -4000, 0, 0));
        repeat (15) send_sample(pack_sample(0, 0, -4000, 0, 0));
        // Extreme accel, gyro rate and time; the averages stay within the reset limits, so accel path
        send_sample(pack_sample(32767, 32767, -32768, 32767, 65535));
        repeat (3) send_sample(pack_sample(-32768, 32767, 32767, -32768, 65535));
        // Axis2 at full scale; its average still stays within the reset limit, so accel path
        repeat (4) send_sample(pack_sample(0, 0, 32767, 1234, 100));
        drain();

        write_reg(REG_ANGLE_THRESH, 16'(-256));
        write_reg(REG_ANGLE_THRESH, 16'(-2880));
        write_reg(REG_ANGLE_THRESH, 16'd2880);
        random_regs(1);
        repeat (8) send_sample(pack_sample($urandom(), $urandom(), $urandom(),
                                           $urandom(), $urandom()));
        drain();

        // Random phases, each with fresh register settings
        for (int ph = 0; ph < 12; ph++) begin
            random_regs(ph == 5);
            if (ph >= 10) idle_on = 0;
            lvl1 = $urandom_range(0, 40000) - 20000;
            lvl2 = $urandom_range(0, 40000) - 20000;
            for (int n = 0; n < 140; n++) begin
                if (n % 35 == 0) begin
                    lvl1 = $urandom_range(0, 40000) - 20000;
                    lvl2 = $urandom_range(0, 40000) - 20000;
                end
                send_sample({(($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                           : 16'($urandom_range(0, 50))),
                             16'($urandom()), near(lvl2), near(lvl1), near(lvl1)});
            end
            drain();
        end

        if (errors == 0)
            $display("tilt_rotation_filter_core: match");
        else
            $display("tilt_rotation_filter_core: mismatch");
        $finish;
    end

    // Watchdog
    initial begin
        #4000000;
        $display("tilt_rotation_filter_core: mismatch");
        $finish;
    end

endmodule
